// ===== hw/rtl/tles_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tles_pkg
// shared types and constants of the tree lca edge saliency unit
// ----------------------------------------------------------------------------
package tles_pkg;

  localparam int IDX_W           = 12;
  localparam int WEIGHT_IN_W     = 32;
  localparam int NODE_COUNT_DEF  = 4096;
  localparam int WEIGHT_BITS_DEF = 32;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // status codes
  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_FAULT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CLIMB
  } tles_state_t;

  typedef struct packed {
    logic                   action;
    logic [IDX_W-1:0]       node_index;
    logic [IDX_W-1:0]       parent_index;
    logic [IDX_W-1:0]       node_depth;
    logic [WEIGHT_IN_W-1:0] node_weight;
    logic [IDX_W-1:0]       edge_u;
    logic [IDX_W-1:0]       edge_v;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]       ancestor_node;
    logic [WEIGHT_IN_W-1:0] saliency;
    logic                   status;
  } out_item_t;

endpackage

// ===== hw/rtl/tles_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tles_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module tles_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/tree_lca_edge_saliency_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lca_edge_saliency_unit
// lowest common ancestor of a leaf edge by depth climbing, with node weight
// ----------------------------------------------------------------------------
// usage:
//   in_ channel carries one item per handshake. a load item (action 0) writes
//   parent, depth and weight of one node and yields no result. a query item
//   (action 1) names an edge (edge_u, edge_v) and yields exactly one result
//   item on the out_ channel.
// climb:
//   a query climbs from accept until the result register is loaded, taking n
//   climb steps (depth difference plus climbs to the meeting node, at most
//   2*NODE_COUNT). each step reads the node table at two addresses and waits
//   for its registered read data. in_stall is high while a query climbs or
//   waits to emit; loads go one per cycle while in_stall is low.
// reset:
//   clears the control state only; the node table keeps no valid bits and
//   reading a node never loaded gives an undefined result.
// receiver stall:
//   the result waits in the output register; new items are still taken while
//   it waits, but a finished query holds its state until the register frees.
// ----------------------------------------------------------------------------
module tree_lca_edge_saliency_unit
  import tles_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int ENTRY_W    = 2 * IDX_W + WEIGHT_BITS;
  localparam int STEP_LIMIT = 2 * NODE_COUNT;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

  // node entry layout: {parent, depth, weight}
  localparam int PAR_LSB = IDX_W + WEIGHT_BITS;
  localparam int DEP_LSB = WEIGHT_BITS;

  tles_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  u_r, u_nxt;
  logic [IDX_W-1:0]  v_r, v_nxt;
  logic              bad_r, bad_nxt;       // endpoint out of range
  logic              lock_r, lock_nxt;     // depths matched, both sides climb together
  logic [STEP_W-1:0] steps_r, steps_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic in_fire;
  logic out_free;
  logic mem_we;
  logic emit;

  logic [ENTRY_W-1:0] rd_a, rd_b;
  logic [ENTRY_W-1:0] wr_entry;

  logic [IDX_W-1:0]       pu, pv, du, dv;
  logic [WEIGHT_BITS-1:0] wu;
  logic                   pu_bad, pv_bad, limit_hit;

  // climb step decision
  logic fin, fault, adv_u, adv_v;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // node table: both endpoints read every cycle, loads write one entry
  // ---------------------------------------------------------------------------
  assign wr_entry = {in_item.parent_index, in_item.node_depth,
                     WEIGHT_BITS'(in_item.node_weight)};

  tles_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (ADDR_W'(in_item.node_index)),
    .wdata   (wr_entry),
    .raddr_a (ADDR_W'(u_nxt)),
    .rdata_a (rd_a),
    .raddr_b (ADDR_W'(v_nxt)),
    .rdata_b (rd_b)
  );

  assign pu = rd_a[PAR_LSB +: IDX_W];
  assign du = rd_a[DEP_LSB +: IDX_W];
  assign wu = rd_a[WEIGHT_BITS-1:0];
  assign pv = rd_b[PAR_LSB +: IDX_W];
  assign dv = rd_b[DEP_LSB +: IDX_W];

  // a parent equal to the node itself is the root: climbing it is a fault
  assign pu_bad    = (pu == u_r) || (32'(pu) >= NODE_COUNT);
  assign pv_bad    = (pv == v_r) || (32'(pv) >= NODE_COUNT);
  assign limit_hit = (steps_r >= STEP_W'(STEP_LIMIT));

  // ---------------------------------------------------------------------------
  // one climb step per cycle on the entries read for u_r and v_r
  // once depths have matched, depths are no longer looked at
  // ---------------------------------------------------------------------------
  always_comb begin
    fin   = 1'b0;
    fault = 1'b0;
    adv_u = 1'b0;
    adv_v = 1'b0;
    priority if (bad_r) begin
      fin   = 1'b1;
      fault = 1'b1;
    end else if (!lock_r && (du != dv)) begin
      // equalize depths: only the deeper side moves
      priority if (limit_hit) begin
        fin   = 1'b1;
        fault = 1'b1;
      end else if (du > dv) begin
        if (pu_bad) begin
          fin   = 1'b1;
          fault = 1'b1;
        end else begin
          adv_u = 1'b1;
        end
      end else begin
        if (pv_bad) begin
          fin   = 1'b1;
          fault = 1'b1;
        end else begin
          adv_v = 1'b1;
        end
      end
    end else if (u_r == v_r) begin
      fin = 1'b1;       // met: u_r is the ancestor, its weight is in rd_a
    end else begin
      // same depth reached, not met: both sides move together
      if (limit_hit || pu_bad || pv_bad) begin
        fin   = 1'b1;
        fault = 1'b1;
      end else begin
        adv_u = 1'b1;
        adv_v = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_item.action == ACT_QUERY)) begin
          state_nxt = ST_CLIMB;
        end
      end
      ST_CLIMB: begin
        if (fin && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    mem_we   = in_fire && (in_item.action == ACT_LOAD) &&
               (32'(in_item.node_index) < NODE_COUNT);
    emit     = (state_r == ST_CLIMB) && fin && out_free;
  end

  // ---------------------------------------------------------------------------
  // climb registers; a finished query holds while the output is full
  // ---------------------------------------------------------------------------
  always_comb begin
    u_nxt     = u_r;
    v_nxt     = v_r;
    bad_nxt   = bad_r;
    lock_nxt  = lock_r;
    steps_nxt = steps_r;
    if (in_fire && (in_item.action == ACT_QUERY)) begin
      u_nxt     = in_item.edge_u;
      v_nxt     = in_item.edge_v;
      bad_nxt   = (32'(in_item.edge_u) >= NODE_COUNT) ||
                  (32'(in_item.edge_v) >= NODE_COUNT);
      lock_nxt  = 1'b0;
      steps_nxt = '0;
    end else if ((state_r == ST_CLIMB) && !fin) begin
      if (adv_u) begin
        u_nxt = pu;
      end
      if (adv_v) begin
        v_nxt = pv;
      end
      if (adv_u && adv_v) begin
        lock_nxt = 1'b1;
      end
      steps_nxt = steps_r + STEP_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (fault) begin
        out_item_nxt.ancestor_node = '0;
        out_item_nxt.saliency      = '0;
        out_item_nxt.status        = STATUS_FAULT;
      end else begin
        out_item_nxt.ancestor_node = u_r;
        out_item_nxt.saliency      = WEIGHT_IN_W'(wu);
        out_item_nxt.status        = STATUS_FOUND;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bad_r       <= 1'b0;
      lock_r      <= 1'b0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bad_r       <= bad_nxt;
      lock_r      <= lock_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result only appears at the end of a climb
  a_result_from_climb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CLIMB))
    else $error("result without a climb");

  // a fault result carries zero node and zero saliency
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == STATUS_FAULT)) |->
      (out_item_r.ancestor_node == '0) && (out_item_r.saliency == '0))
    else $error("fault result with nonzero fields");

  // the step counter never runs past the climb limit
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(STEP_LIMIT))
    else $error("step counter past limit");

  // a valid climb only walks through nodes inside the table
  a_climb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CLIMB) && !bad_r) |->
      (32'(u_r) < NODE_COUNT) && (32'(v_r) < NODE_COUNT))
    else $error("climb left the node table");

endmodule
